FILE: src/sdcgm_pkg.sv
// Shared types, command codes and ring-size helpers of the sparse-dense cyclic GF(2) multiplier.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package sdcgm_pkg;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_TERM  = 2'd2,
        CMD_READ  = 2'd3
    } sdcgm_cmd_t;

    typedef struct packed {
        sdcgm_cmd_t  cmd;
        logic [9:0]  word_index;
        logic [63:0] data_word;
        logic [15:0] term_position;
    } sdcgm_item_t;

    typedef struct packed {
        logic [63:0] result_word;
        logic        stopped;
    } sdcgm_result_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD,
        ST_RUN,
        ST_DRAIN,
        ST_RESULT
    } sdcgm_state_t;

    typedef struct packed {
        logic load;
        logic clear;
        logic setup;
        logic step;
        logic rd;
    } sdcgm_ctrl_t;

    function automatic int sdcgm_ring_len(input int ring_bits, input int words);
        return (ring_bits < words * 64) ? ring_bits : words * 64;
    endfunction

    function automatic int sdcgm_ring_words(input int ring_len);
        return (ring_len + 63) >> 6;
    endfunction

endpackage

FILE: src/sdcgm_mod_unit.sv
// Iterative reduction of a term exponent modulo the ring length, one compare and subtract a cycle.
// Depends on sdcgm_pkg for the ring-length helper.
`timescale 1ns / 1ps

module sdcgm_mod_unit #(
    parameter int RING_BITS = 17669,
    parameter int WORDS     = 277
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [15:0] pos,
    output logic        done,
    output logic [15:0] rem
);
    import sdcgm_pkg::*;

    localparam int          RING_LEN = sdcgm_ring_len(RING_BITS, WORDS);
    localparam logic [31:0] LEN_WIDE = 32'(RING_LEN);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [3:0]  step_reg, step_next;
    logic [15:0] rem_reg, rem_next;
    logic [31:0] divisor;

    assign divisor = LEN_WIDE << step_reg;

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        rem_next  = rem_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = 4'd15;
            rem_next  = pos;
        end
        else if (busy_reg)
        begin
            if ({16'h0000, rem_reg} >= divisor)
            begin
                rem_next = rem_reg - divisor[15:0];
            end
            step_next = step_reg - 4'd1;
            if (step_reg == 4'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 4'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

FILE: src/sdcgm_datapath.sv
// Dense and product memories with the funnel-shift and XOR unit that folds one word per cycle.
// Depends on sdcgm_pkg for the control struct and the ring-size helpers.
`timescale 1ns / 1ps

module sdcgm_datapath #(
    parameter int RING_BITS = 17669,
    parameter int WORDS     = 277
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  sdcgm_pkg::sdcgm_ctrl_t            ctrl,
    input  logic [$clog2(WORDS + 1) - 1:0]    cnt,
    input  logic [9:0]                        word_index,
    input  logic [63:0]                       data_word,
    input  logic [15:0]                       rem,
    output logic [63:0]                       rdata
);
    import sdcgm_pkg::*;

    localparam int          AW       = $clog2(WORDS);
    localparam int          CW       = $clog2(WORDS + 1);
    localparam int          XW       = CW + 1;
    localparam int          RING_LEN = sdcgm_ring_len(RING_BITS, WORDS);
    localparam int          L        = sdcgm_ring_words(RING_LEN);
    localparam int          R        = RING_LEN - 64 * (L - 1);
    localparam logic [63:0] RMASK    = {64{1'b1}} >> (64 - R);
    localparam logic [15:0] LEN16    = 16'(RING_LEN);
    localparam logic [XW-1:0] L_X    = XW'(L);
    localparam logic [XW-1:0] LAST_X = XW'(L - 1);
    localparam logic [AW-1:0] LAST_W = AW'(L - 1);

    logic [63:0] dense_mem [WORDS];
    logic [63:0] prod_mem  [WORDS];

    logic [5:0]    sa_reg, sb_reg;
    logic [CW-1:0] a_reg, q_reg;
    logic [15:0]   t_val;

    logic [XW-1:0] kx, ax, idx_a, idx_b;
    logic          valid_a, valid_b, idx_ok;
    logic [AW-1:0] raddr_a, raddr_b, paddr, waddr;
    logic          prod_re, prod_we;
    logic [63:0]   wdata;

    logic [63:0]   qa_reg, qb_reg, qp_reg;
    logic [63:0]   preva_reg, prevb_reg;
    logic          s1_valid_reg, s1_write_reg, s1_lastw_reg;
    logic          s1_va_reg, s1_vb_reg, s1_la_reg, s1_lb_reg;
    logic [AW-1:0] s1_w_reg;
    logic          rd_ok_reg;

    logic [63:0]   da, db, nw;
    logic [127:0]  fun_a, fun_b;
    logic [6:0]    sh_a;

    assign t_val  = LEN16 - rem;
    assign idx_ok = {1'b0, word_index} < 11'(WORDS);

    assign kx      = XW'(cnt);
    assign ax      = XW'(a_reg) + XW'(1);
    assign valid_a = kx >= ax;
    assign idx_a   = kx - ax;
    assign idx_b   = kx + XW'(q_reg);
    assign valid_b = idx_b < L_X;
    assign raddr_a = valid_a ? idx_a[AW-1:0] : '0;
    assign raddr_b = valid_b ? idx_b[AW-1:0] : '0;

    assign prod_re = ctrl.step || ctrl.rd;
    assign paddr   = ctrl.step ? ((cnt != '0) ? AW'(cnt - CW'(1)) : '0)
                               : (idx_ok ? word_index[AW-1:0] : '0);

    assign da = s1_va_reg ? (s1_la_reg ? (qa_reg & RMASK) : qa_reg) : 64'h0;
    assign db = s1_vb_reg ? (s1_lb_reg ? (qb_reg & RMASK) : qb_reg) : 64'h0;

    assign sh_a  = 7'd64 - {1'b0, sa_reg};
    assign fun_a = {da, preva_reg} >> sh_a;
    assign fun_b = {db, prevb_reg} >> sb_reg;

    always_comb
    begin
        nw = qp_reg ^ fun_a[63:0] ^ fun_b[63:0];
        if (s1_lastw_reg)
        begin
            nw = nw & RMASK;
        end
    end

    assign prod_we = ctrl.clear || (s1_valid_reg && s1_write_reg);
    assign waddr   = ctrl.clear ? cnt[AW-1:0] : s1_w_reg;
    assign wdata   = ctrl.clear ? 64'h0 : nw;

    always_ff @(posedge clk)
    begin
        if (ctrl.load && idx_ok)
        begin
            dense_mem[word_index[AW-1:0]] <= data_word;
        end
        qa_reg <= dense_mem[raddr_a];
        qb_reg <= dense_mem[raddr_b];
    end

    always_ff @(posedge clk)
    begin
        if (prod_we)
        begin
            prod_mem[waddr] <= wdata;
        end
        if (prod_re)
        begin
            qp_reg <= prod_mem[paddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.setup)
        begin
            sa_reg <= rem[5:0];
            a_reg  <= CW'(rem >> 6);
            sb_reg <= t_val[5:0];
            q_reg  <= CW'(t_val >> 6);
        end
        if (ctrl.step)
        begin
            s1_w_reg     <= AW'(cnt - CW'(1));
            s1_lastw_reg <= (AW'(cnt - CW'(1)) == LAST_W);
            s1_va_reg    <= valid_a;
            s1_vb_reg    <= valid_b;
            s1_la_reg    <= valid_a && (idx_a == LAST_X);
            s1_lb_reg    <= valid_b && (idx_b == LAST_X);
        end
        if (s1_valid_reg)
        begin
            preva_reg <= da;
            prevb_reg <= db;
        end
        if (ctrl.rd)
        begin
            rd_ok_reg <= idx_ok;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_write_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= ctrl.step;
            s1_write_reg <= ctrl.step && (cnt != '0);
        end
    end

    assign rdata = rd_ok_reg ? qp_reg : 64'h0;

endmodule

FILE: src/sparse_dense_cyclic_gf2_multiply.sv
// Top level of the sparse-dense cyclic GF(2) multiplier: command sequencer and result register.
// Depends on sdcgm_pkg, sdcgm_mod_unit and sdcgm_datapath.
`timescale 1ns / 1ps

// The block multiplies a dense binary polynomial by a sparse one modulo X^n - 1, with n the
// smaller of RING_BITS and 64*WORDS. Load the dense operand word by word, clear, send one
// command per sparse term, then read the product back word by word; a read also reports the
// stop flag set by a term above RING_BITS. After reset the block runs a clearing pass over
// the accumulator before it takes its first item, and a clear command runs the same pass. A
// term first reduces its exponent modulo n, then folds one accumulator word per cycle, over L
// words where L is n/64 rounded up, through the two funnel shifters and the single write port
// of the accumulator memory. A read result waits in an output register while the next item
// runs.

module sparse_dense_cyclic_gf2_multiply #(
    parameter int RING_BITS = 17669,
    parameter int WORDS     = 277
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     item_valid,
    output logic                     item_ready,
    input  sdcgm_pkg::sdcgm_item_t   item,
    output logic                     result_valid,
    input  logic                     result_ready,
    output sdcgm_pkg::sdcgm_result_t result
);
    import sdcgm_pkg::*;

    localparam int            CW       = $clog2(WORDS + 1);
    localparam int            RING_LEN = sdcgm_ring_len(RING_BITS, WORDS);
    localparam int            L        = sdcgm_ring_words(RING_LEN);
    localparam logic [CW-1:0] CLR_LAST = CW'(WORDS - 1);
    localparam logic [CW-1:0] RUN_LAST = CW'(L);
    localparam logic [15:0]   POS_MAX  = 16'(RING_BITS);

    sdcgm_state_t  state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          halt_reg, halt_next;
    logic          result_valid_reg, result_valid_next;
    sdcgm_result_t result_reg;

    sdcgm_ctrl_t   ctrl;
    logic          accept, mod_start, mod_done, out_free, term_ok;
    logic [15:0]   mod_rem;
    logic [63:0]   rdata;

    assign accept   = item_valid && item_ready;
    assign out_free = !result_valid_reg || result_ready;
    assign term_ok  = !halt_reg && (item.term_position <= POS_MAX);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (cnt_reg == CLR_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (item.cmd)
                        CMD_LOAD:  state_next = ST_IDLE;
                        CMD_CLEAR: state_next = ST_CLEAR;
                        CMD_TERM:  state_next = term_ok ? ST_MOD : ST_IDLE;
                        CMD_READ:  state_next = ST_RESULT;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_MOD:
            begin
                if (mod_done)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (cnt_reg == RUN_LAST)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_IDLE;
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        item_ready = (state_reg == ST_IDLE);
        ctrl.load  = accept && (item.cmd == CMD_LOAD);
        ctrl.rd    = accept && (item.cmd == CMD_READ);
        ctrl.clear = (state_reg == ST_CLEAR);
        ctrl.setup = (state_reg == ST_MOD) && mod_done;
        ctrl.step  = (state_reg == ST_RUN);
        mod_start  = accept && (item.cmd == CMD_TERM) && term_ok;
    end

    always_comb
    begin
        cnt_next          = cnt_reg;
        halt_next         = halt_reg;
        result_valid_next = result_valid_reg;
        if (result_valid_reg && result_ready)
        begin
            result_valid_next = 1'b0;
        end
        if ((state_reg == ST_CLEAR) || (state_reg == ST_RUN))
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        if (ctrl.setup)
        begin
            cnt_next = '0;
        end
        if (accept && (item.cmd == CMD_CLEAR))
        begin
            cnt_next  = '0;
            halt_next = 1'b0;
        end
        if (accept && (item.cmd == CMD_TERM) && !halt_reg && (item.term_position > POS_MAX))
        begin
            halt_next = 1'b1;
        end
        if ((state_reg == ST_RESULT) && out_free)
        begin
            result_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            cnt_reg          <= '0;
            halt_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            cnt_reg          <= cnt_next;
            halt_reg         <= halt_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_RESULT) && out_free)
        begin
            result_reg.result_word <= rdata;
            result_reg.stopped     <= halt_reg;
        end
    end

    sdcgm_mod_unit #(
        .RING_BITS (RING_BITS),
        .WORDS     (WORDS)
    ) u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mod_start),
        .pos   (item.term_position),
        .done  (mod_done),
        .rem   (mod_rem)
    );

    sdcgm_datapath #(
        .RING_BITS (RING_BITS),
        .WORDS     (WORDS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .cnt        (cnt_reg),
        .word_index (item.word_index),
        .data_word  (item.data_word),
        .rem        (mod_rem),
        .rdata      (rdata)
    );

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

FILE: tb/sparse_dense_cyclic_gf2_multiply_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of sparse_dense_cyclic_gf2_multiply: loads a dense operand and drives
// clear, term and read transfers with random bursts and result stalls, checking each read word.
// Depends on sdcgm_pkg and the block's RTL.

module sparse_dense_cyclic_gf2_multiply_tb;
    import sdcgm_pkg::*;

    localparam int RING_BITS = 17669;
    localparam int WORDS = 277;
    localparam int RING_N = (RING_BITS < WORDS * 64) ? RING_BITS : WORDS * 64;
    localparam int RANDOM_ITEMS = 700;
    localparam int DRAIN_CYCLES = 700;
    localparam int CYCLE_LIMIT = 3000000;

    logic clk;
    logic rst_n;
    logic item_valid;
    logic item_ready;
    sdcgm_item_t item;
    logic result_valid;
    logic result_ready;
    sdcgm_result_t result;

    sdcgm_item_t commands_to_send[$];
    sdcgm_result_t reads_due[$];

    logic [63:0] dense_words[WORDS];
    logic [63:0] product_words[WORDS];
    logic halted;

    logic item_taken;
    int gap_left;
    int burst_left;
    int stall_mode;
    int stall_left;
    int cycle_count;
    int mismatches;
    int loads_seen;
    int clears_seen;
    int terms_applied;
    int halts_seen;
    int reads_checked;

    sparse_dense_cyclic_gf2_multiply #(
        .RING_BITS(RING_BITS),
        .WORDS    (WORDS)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item        (item),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result      (result)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t ns: %s", $time, msg);
        mismatches++;
    endtask

    function automatic void apply_to_product(input sdcgm_item_t it);
        int shift;
        int src;
        int dst;
        sdcgm_result_t want;
        case (it.cmd)
            CMD_LOAD:
            begin
                loads_seen++;
                if (it.word_index < WORDS)
                    dense_words[it.word_index] = it.data_word;
            end
            CMD_CLEAR:
            begin
                clears_seen++;
                foreach (product_words[w])
                    product_words[w] = '0;
                halted = 1'b0;
            end
            CMD_TERM:
            begin
                if (!halted && int'(it.term_position) > RING_BITS)
                begin
                    halted = 1'b1;
                    halts_seen++;
                end
                else if (!halted)
                begin
                    shift = int'(it.term_position) % RING_N;
                    dst = shift;
                    for (src = 0; src < RING_N; src++)
                    begin
                        if (dense_words[src / 64][src % 64])
                            product_words[dst / 64][dst % 64] = ~product_words[dst / 64][dst % 64];
                        dst++;
                        if (dst == RING_N)
                            dst = 0;
                    end
                    terms_applied++;
                end
            end
            default:
            begin
                want.result_word = (it.word_index < WORDS) ? product_words[it.word_index] : 64'd0;
                want.stopped = halted;
                reads_due.push_back(want);
            end
        endcase
    endfunction

    task automatic check_read(input sdcgm_result_t got);
        sdcgm_result_t want;
        if (reads_due.size() == 0)
        begin
            report_mismatch($sformatf("unexpected result word %h stopped %b",
                                      got.result_word, got.stopped));
        end
        else
        begin
            want = reads_due.pop_front();
            if (got.result_word !== want.result_word)
                report_mismatch($sformatf("result_word %h, expected %h",
                                          got.result_word, want.result_word));
            if (got.stopped !== want.stopped)
                report_mismatch($sformatf("stopped %b, expected %b", got.stopped, want.stopped));
            reads_checked++;
        end
    endtask

    task automatic send(input sdcgm_cmd_t c, input int idx, input logic [63:0] data,
                        input int pos);
        sdcgm_item_t it;
        it.cmd = c;
        it.word_index = idx[9:0];
        it.data_word = data;
        it.term_position = pos[15:0];
        commands_to_send.push_back(it);
    endtask

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] rand_dense();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 85)
            return rand_word();
        else if (roll < 90)
            return '1;
        else if (roll < 95)
            return 64'd1 << $urandom_range(0, 63);
        return '0;
    endfunction

    function automatic int rand_index();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 88)
            return $urandom_range(0, WORDS - 1);
        else if (roll < 94)
            return WORDS - 1;
        return $urandom_range(WORDS, 1023);
    endfunction

    function automatic int pick_position();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 66)
            return $urandom_range(0, RING_BITS);
        else if (roll < 74)
            return RING_BITS;
        else if (roll < 82)
            return $urandom_range(0, 70);
        else if (roll < 92)
            return $urandom_range(RING_BITS - 70, RING_BITS - 1);
        else if (roll < 95)
            return RING_BITS + 1;
        return $urandom_range(RING_BITS + 1, 65535);
    endfunction

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[sparse_dense_cyclic_gf2_multiply] ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        item_taken <= item_valid && item_ready;
        if (rst_n)
        begin
            if (result_valid && result_ready)
                check_read(result);
            if (item_valid && item_ready)
                apply_to_product(item);
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && (!item_valid || item_taken))
        begin
            if (gap_left == 0 && commands_to_send.size() > 0)
            begin
                item <= commands_to_send.pop_front();
                item_valid <= 1'b1;
                burst_left = burst_left - 1;
                if (burst_left <= 0)
                begin
                    if ($urandom_range(0, 3) == 0)
                    begin
                        gap_left = 0;
                        burst_left = $urandom_range(20, 80);
                    end
                    else
                    begin
                        gap_left = $urandom_range(1, 12);
                        burst_left = $urandom_range(1, 10);
                    end
                end
            end
            else
            begin
                item_valid <= 1'b0;
                if (gap_left > 0)
                    gap_left = gap_left - 1;
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (stall_left == 0)
            begin
                stall_mode = $urandom_range(0, 2);
                stall_left = (stall_mode == 2) ? $urandom_range(1, 40) : $urandom_range(20, 200);
            end
            stall_left = stall_left - 1;
            case (stall_mode)
                0: result_ready <= 1'b1;
                1: result_ready <= ($urandom_range(0, 1) == 1);
                default: result_ready <= 1'b0;
            endcase
        end
    end

    initial
    begin
        int target;
        int nloads;
        int nterms;
        int nreads;

        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        result_ready = 1'b0;
        item_taken = 1'b0;
        halted = 1'b0;
        gap_left = 0;
        burst_left = 0;
        stall_mode = 0;
        stall_left = 0;
        cycle_count = 0;
        mismatches = 0;
        loads_seen = 0;
        clears_seen = 0;
        terms_applied = 0;
        halts_seen = 0;
        reads_checked = 0;
        foreach (product_words[w])
            product_words[w] = '0;

        // Every dense word is written before the first term reads the operand.
        for (int w = 0; w < WORDS; w++)
            send(CMD_LOAD, w, rand_dense(), $urandom_range(0, 65535));

        send(CMD_READ, 0, rand_word(), 0);
        send(CMD_TERM, 0, rand_word(), 0);
        send(CMD_READ, 0, '1, 65535);
        send(CMD_READ, WORDS - 1, rand_word(), 0);
        send(CMD_READ, WORDS, rand_word(), 0);
        send(CMD_READ, 1023, rand_word(), 0);
        send(CMD_TERM, 0, rand_word(), RING_BITS);
        send(CMD_READ, 0, rand_word(), 0);
        send(CMD_TERM, 5, rand_word(), 1);
        send(CMD_TERM, 5, rand_word(), RING_BITS - 1);
        send(CMD_TERM, 5, rand_word(), 64);
        send(CMD_TERM, 5, rand_word(), 63);
        send(CMD_READ, WORDS - 1, rand_word(), 0);
        send(CMD_READ, 100, rand_word(), 0);
        send(CMD_TERM, 0, rand_word(), RING_BITS + 1);
        send(CMD_TERM, 0, rand_word(), 5);
        send(CMD_READ, 0, rand_word(), 0);
        send(CMD_CLEAR, 1023, '1, 65535);
        send(CMD_READ, 0, rand_word(), 0);
        send(CMD_LOAD, WORDS, '1, 0);
        send(CMD_LOAD, 1023, '1, 0);
        send(CMD_LOAD, WORDS - 1, '1, 0);
        send(CMD_TERM, 0, '0, 7);
        send(CMD_READ, WORDS - 1, '0, 0);
        send(CMD_TERM, 0, '0, 65535);
        send(CMD_READ, 0, '0, 0);

        target = commands_to_send.size() + RANDOM_ITEMS;
        while (commands_to_send.size() < target)
        begin
            if ($urandom_range(0, 99) < 8)
            begin
                send(sdcgm_cmd_t'($urandom_range(0, 3)), $urandom_range(0, 1023), rand_word(),
                     $urandom_range(0, 65535));
            end
            else
            begin
                if ($urandom_range(0, 99) < 65)
                    send(CMD_CLEAR, $urandom_range(0, 1023), rand_word(), $urandom_range(0, 65535));
                nloads = $urandom_range(0, 2);
                nterms = $urandom_range(1, 3);
                nreads = $urandom_range(2, 8);
                repeat (nloads)
                    send(CMD_LOAD, rand_index(), rand_dense(), $urandom_range(0, 65535));
                repeat (nterms)
                    send(CMD_TERM, $urandom_range(0, 1023), rand_word(), pick_position());
                repeat (nreads)
                    send(CMD_READ, rand_index(), rand_word(), $urandom_range(0, 65535));
            end
        end

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (commands_to_send.size() > 0 || item_valid)
            @(posedge clk);
        while (reads_due.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d loads, %0d clears, %0d terms applied and %0d halting terms.",
                 loads_seen, clears_seen, terms_applied, halts_seen);
        $display("%0d read results compared, %0d mismatches.", reads_checked, mismatches);
        if (mismatches == 0)
            $display("[sparse_dense_cyclic_gf2_multiply] OK");
        else
            $display("[sparse_dense_cyclic_gf2_multiply] ERROR");
        $finish;
    end

endmodule
